### sv/hat_pkg.sv
// Package for the hash accumulate table: sizes, types and operation codes.
`default_nettype none
package hat_pkg;
    localparam int NUM_BUCKETS = 256;
    localparam int WAYS        = 4;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int CNT_W       = $clog2(NUM_BUCKETS + 1);
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [1:0] {
        MODE_FIND = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_DEL  = 2'd2,
        MODE_NOP  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_CMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                     valid;
        logic [WAYS-1:0]          vbits;
        logic [WAYS-1:0][31:0]    keys;
        logic [WAYS-1:0][31:0]    sums;
    } t_bucket;

    // One bucket write: valid row, key row and sum row at once.
    typedef struct packed {
        logic                     en;
        logic [BKT_W-1:0]         addr;
        logic [WAYS-1:0]          vbits;
        logic [WAYS-1:0][31:0]    keys;
        logic [WAYS-1:0][31:0]    sums;
    } t_bwrite;
endpackage
`default_nettype wire

### sv/hat_mod.sv
// Restoring divider that reduces a 32-bit key modulo the bucket count, one bit a cycle.
`default_nettype none
module hat_mod (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [31:0]               i_key,
    input  wire logic [hat_pkg::CNT_W-1:0] i_div,
    output logic                           o_done,
    output logic [hat_pkg::BKT_W-1:0]      o_rem
);
    logic [31:0]               r_q, n_q;
    logic [hat_pkg::CNT_W:0]   r_r, n_r;
    logic [5:0]                r_cnt, n_cnt;
    logic                      r_busy, n_busy;
    logic [hat_pkg::CNT_W:0]   w_t;

    always_comb begin
        n_q = r_q; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy;
        w_t = {r_r[hat_pkg::CNT_W-1:0], r_q[31]};
        if (i_start) begin
            n_q = i_key; n_r = '0; n_cnt = 6'd32; n_busy = 1'b1;
        end else if (r_busy) begin
            n_q = {r_q[30:0], 1'b0};
            n_r = (w_t >= {1'b0, i_div}) ? w_t - {1'b0, i_div} : w_t;
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r;
    end

    assign o_done = r_busy && (r_cnt == 6'd0) ? 1'b0 : (!r_busy && r_cnt == 6'd0);
    assign o_rem  = r_r[hat_pkg::BKT_W-1:0];
endmodule
`default_nettype wire

### sv/hat_store.sv
// Bucket store: valid flags and key and sum rows in synchronous RAMs with a registered read.
`default_nettype none
module hat_store (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd,
    input  wire logic [hat_pkg::BKT_W-1:0] i_rd_addr,
    input  wire hat_pkg::t_bwrite          i_wr,
    output hat_pkg::t_bucket               o_rd,
    output logic                           o_clearing
);
    localparam int NB = hat_pkg::NUM_BUCKETS;
    localparam int W  = hat_pkg::WAYS;

    logic [W-1:0]                 r_valid [NB];
    logic [2*W*32-1:0]            r_mem   [NB];
    logic [2*W*32-1:0]            r_data;
    logic [W-1:0]                 r_vout;
    logic                         r_rdv;
    logic                         r_clearing;
    logic [hat_pkg::BKT_W-1:0]    r_clr;

    always_ff @(posedge i_clk) begin
        if (i_rd) r_data <= r_mem[i_rd_addr];
        if (i_wr.en) r_mem[i_wr.addr] <= {i_wr.keys, i_wr.sums};
    end

    // After reset the valid flags are zeroed one bucket a cycle, all NUM_BUCKETS buckets in turn.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1; r_clr <= '0; r_rdv <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == hat_pkg::BKT_W'(NB - 1)) r_clearing <= 1'b0;
            end
            r_rdv <= i_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_clearing) r_valid[r_clr] <= '0;
        else if (i_wr.en) r_valid[i_wr.addr] <= i_wr.vbits;
        if (i_rd) r_vout <= r_valid[i_rd_addr];
    end

    assign o_clearing = r_clearing;
    assign o_rd.valid = r_rdv;
    assign o_rd.vbits = r_vout;
    assign o_rd.keys  = r_data[2*W*32-1:W*32];
    assign o_rd.sums  = r_data[W*32-1:0];
endmodule
`default_nettype wire

### sv/hash_accumulate_table.sv
// Top level of the hash accumulate table: control, divider and bucket store.
// A word's result is offered after the bit-serial key modulo (start, 32 steps, done),
// the bucket RAM read and a compare state that writes back and loads the output
// register. One word is in flight at a time; the next is accepted the cycle after
// the result is taken.
// After reset a pass clears the valid flags before the first word; bucket_count resets to 256.
`default_nettype none
module hash_accumulate_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_key,
    input  wire logic signed [31:0] i_add_amount,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_found,
    output logic signed [31:0] o_sum,
    output logic             o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [8:0]  i_cfg_data
);
    localparam int W = hat_pkg::WAYS;

    hat_pkg::t_state r_state, n_state;
    logic [8:0]  r_bc;
    logic [1:0]  r_mode;
    logic [31:0] r_key, r_amt;
    logic [hat_pkg::BKT_W-1:0] r_bkt;
    logic        r_ov, r_found, r_status;
    logic [31:0] r_sum;
    logic        r_started;
    logic        w_acc, w_div_start, w_div_done, w_rd, w_cmp, w_clearing;
    logic [hat_pkg::CNT_W-1:0] w_div;
    logic [hat_pkg::BKT_W-1:0] w_rem;
    hat_pkg::t_bucket w_bk;
    hat_pkg::t_bwrite w_wr;
    logic        w_hit, w_free, w_found, w_status;
    logic [hat_pkg::WAY_W-1:0] w_hw, w_fw;
    logic [31:0] w_sum;

    always_comb begin
        if (r_bc == 9'd0) w_div = hat_pkg::CNT_W'(1);
        else if (r_bc > 9'(hat_pkg::NUM_BUCKETS)) w_div = hat_pkg::CNT_W'(hat_pkg::NUM_BUCKETS);
        else w_div = hat_pkg::CNT_W'(r_bc);
    end

    assign o_cfg_ready = 1'b1;
    assign w_acc = i_valid && o_ready;

    hat_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_key(r_key),
        .i_div(w_div), .o_done(w_div_done), .o_rem(w_rem)
    );

    hat_store u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd(w_rd), .i_rd_addr(r_bkt),
        .i_wr(w_wr), .o_rd(w_bk), .o_clearing(w_clearing)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hat_pkg::ST_IDLE: if (w_acc) n_state = hat_pkg::ST_DIV;
            hat_pkg::ST_DIV:  if (w_div_done && r_started) n_state = hat_pkg::ST_RD;
            hat_pkg::ST_RD:   n_state = hat_pkg::ST_CMP;
            hat_pkg::ST_CMP:  n_state = hat_pkg::ST_OUT;
            hat_pkg::ST_OUT:  if (!r_ov || i_ready) n_state = hat_pkg::ST_IDLE;
            default:          n_state = hat_pkg::ST_IDLE;
        endcase
    end

    // The divider is started in the cycle after acceptance, once the key is registered.
    // Its done flag is also high while it is idle, so r_started marks a started division.
    always_comb begin
        o_ready = 1'b0; w_div_start = 1'b0; w_rd = 1'b0; w_cmp = 1'b0;
        unique case (r_state)
            hat_pkg::ST_IDLE: o_ready = !w_clearing;
            hat_pkg::ST_DIV:  w_div_start = !r_started;
            hat_pkg::ST_RD:   w_rd = 1'b1;
            hat_pkg::ST_CMP:  w_cmp = 1'b1;
            default: ;
        endcase
    end

    // Lowest matching way and lowest free way.
    always_comb begin
        w_hit = 1'b0; w_free = 1'b0; w_hw = '0; w_fw = '0;
        for (int w = W-1; w >= 0; w--) begin
            if (w_bk.vbits[w] && w_bk.keys[w] == r_key) begin
                w_hit = 1'b1; w_hw = hat_pkg::WAY_W'(w);
            end
            if (!w_bk.vbits[w]) begin
                w_free = 1'b1; w_fw = hat_pkg::WAY_W'(w);
            end
        end
    end

    always_comb begin
        w_wr.en = 1'b0; w_wr.addr = r_bkt;
        w_wr.vbits = w_bk.vbits; w_wr.keys = w_bk.keys; w_wr.sums = w_bk.sums;
        w_found = 1'b0; w_sum = '0; w_status = 1'b0;
        case (r_mode)
            hat_pkg::MODE_FIND: if (w_hit) begin
                w_found = 1'b1; w_sum = w_bk.sums[w_hw];
            end
            hat_pkg::MODE_ADD: if (w_hit) begin
                w_found = 1'b1; w_sum = w_bk.sums[w_hw] + r_amt;
                w_wr.sums[w_hw] = w_sum; w_wr.en = w_cmp;
            end else if (w_free) begin
                w_sum = r_amt;
                w_wr.vbits[w_fw] = 1'b1; w_wr.keys[w_fw] = r_key;
                w_wr.sums[w_fw] = r_amt; w_wr.en = w_cmp;
            end else begin
                w_status = 1'b1;
            end
            hat_pkg::MODE_DEL: if (w_hit) begin
                w_found = 1'b1; w_sum = w_bk.sums[w_hw];
                w_wr.vbits[w_hw] = 1'b0; w_wr.en = w_cmp;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hat_pkg::ST_IDLE; r_bc <= 9'd256; r_ov <= 1'b0; r_started <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_bc <= i_cfg_data;
            r_started <= (r_state == hat_pkg::ST_DIV) && !(w_div_done && r_started);
            if (w_cmp) r_ov <= 1'b1;
            else if (o_valid && i_ready) r_ov <= 1'b0;
        end
        if (w_acc) begin
            r_mode <= i_mode; r_key <= i_key; r_amt <= i_add_amount;
        end
        if (r_state == hat_pkg::ST_DIV && w_div_done && r_started) r_bkt <= w_rem;
        if (w_cmp) begin
            r_found <= w_found; r_sum <= w_sum; r_status <= w_status;
        end
    end

    assign o_valid  = r_ov;
    assign o_found  = r_found;
    assign o_sum    = r_sum;
    assign o_status = r_status;
endmodule
`default_nettype wire

### sv/hat_checker.sv
// Port-level assertions for the hash accumulate table, bound to the top level.
`default_nettype none
module hat_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_found,
    input wire logic [31:0] o_sum,
    input wire logic        o_status
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sum) && $stable(o_found))
        else $error("result changed while stalled");
    a_fullsum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_found && o_sum == 32'd0)
        else $error("full bucket result carries data");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word accepted while busy");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid || !$past(o_valid) || $past(i_ready) == 1'b0)
        else $error("result too early");
endmodule

bind hash_accumulate_table hat_checker u_hat_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_found(o_found), .o_sum(o_sum),
    .o_status(o_status)
);
`default_nettype wire
